// ===== rtl/tdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_pkg: shared types and constants of the time-of-day clock
// Command codes, register indexes, cursor positions, reset values and the
// packed records that carry the clock state and the configuration.
// ----------------------------------------------------------------------------
package tdc_pkg;

  // Command codes carried in an input word
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_FORMAT = 2'd1,
    CMD_SET    = 2'd2,
    CMD_IDLE   = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam int unsigned   CFG_INDEX_W           = 1;
  localparam int unsigned   CFG_DATA_W            = 10;
  localparam logic [CFG_INDEX_W-1:0] REG_TICK_DIVIDE      = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FORMAT_THRESHOLD = 1'b1;

  // Configuration reset values
  localparam logic [7:0] TICK_DIVIDE_RESET      = 8'd125;
  localparam logic [9:0] FORMAT_THRESHOLD_RESET = 10'd512;

  // Time limits
  localparam logic [5:0] LAST_MINUTE    = 6'd59;
  localparam logic [4:0] LAST_HOUR_24   = 5'd23;
  localparam logic [4:0] LAST_HOUR_12   = 5'd11;
  localparam logic [4:0] HALF_DAY       = 5'd12;
  localparam logic [4:0] HOUR_RESET     = 5'd22;

  // Digit-entry cursor positions
  localparam logic [2:0] CUR_OFF         = 3'd0;
  localparam logic [2:0] CUR_HOUR_TENS   = 3'd1;
  localparam logic [2:0] CUR_HOUR_UNITS  = 3'd2;
  localparam logic [2:0] CUR_MIN_TENS    = 3'd3;
  localparam logic [2:0] CUR_MIN_UNITS   = 3'd4;
  localparam logic [2:0] CUR_SEC_TENS    = 3'd5;
  localparam logic [2:0] CUR_SEC_UNITS   = 3'd6;
  localparam logic [2:0] CUR_COMMIT      = 3'd7;

  typedef struct packed {
    logic [7:0] tick_divide;
    logic [9:0] format_threshold;
  } cfg_t;

  typedef struct packed {
    logic [7:0] prescale_count;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       format_24h;
    logic       pm;
    logic [2:0] cursor;
    logic [3:0] tens_digit;
    logic [4:0] staged_hour;
    logic [5:0] staged_minute;
    logic [5:0] staged_second;
  } state_t;

  localparam state_t STATE_RESET = '{
    prescale_count: 8'd0,
    hour:           HOUR_RESET,
    minute:         6'd0,
    second:         6'd0,
    format_24h:     1'b1,
    pm:             1'b0,
    cursor:         CUR_OFF,
    tens_digit:     4'd0,
    staged_hour:    5'd0,
    staged_minute:  6'd0,
    staged_second:  6'd0
  };

endpackage

// ===== rtl/tdc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_if: handshake channels of the time-of-day clock
// Input channel carries command words; result channel carries the time.
// ----------------------------------------------------------------------------
interface tdc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [9:0] adc_value;
  logic [3:0] key_digit;

  modport source (output valid, cmd, adc_value, key_digit, input ready);
  modport sink   (input valid, cmd, adc_value, key_digit, output ready);
endinterface

interface tdc_result_if;
  logic       valid;
  logic       ready;
  logic [4:0] hours;
  logic [5:0] minutes;
  logic [5:0] seconds;
  logic       mode_24h;
  logic [2:0] set_cursor;
  logic       second_pulse;

  modport source (output valid, hours, minutes, seconds, mode_24h, set_cursor,
                  second_pulse, input ready);
  modport sink   (input valid, hours, minutes, seconds, mode_24h, set_cursor,
                  second_pulse, output ready);
endinterface

// ===== rtl/tdc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_cfg_regs: configuration registers
// Holds the prescaler divide value and the 12/24-hour format threshold.
// ----------------------------------------------------------------------------
module tdc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [tdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tdc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output tdc_pkg::cfg_t                      cfg
);

  // Load the addressed register on a write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_divide      <= tdc_pkg::TICK_DIVIDE_RESET;
      cfg.format_threshold <= tdc_pkg::FORMAT_THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tdc_pkg::REG_TICK_DIVIDE:      cfg.tick_divide      <= cfg_data[7:0];
        tdc_pkg::REG_FORMAT_THRESHOLD: cfg.format_threshold <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/tdc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_step: next-state logic of the clock
// Works out the state after one command word: prescaler tick, format switch
// or one press of the set button.
// ----------------------------------------------------------------------------
module tdc_step (
  input  tdc_pkg::cfg_t   cfg,
  input  tdc_pkg::state_t cur,
  input  logic [1:0]      cmd,
  input  logic [9:0]      adc_value,
  input  logic [3:0]      key_digit,
  output tdc_pkg::state_t nxt,
  output logic            pulse
);

  logic [8:0] count_inc;
  logic [4:0] last_hour;
  logic       sec_wrap;
  logic [5:0] tick_sec;
  logic [6:0] min_pre;
  logic       min_wrap;
  logic [5:0] tick_min;
  logic [5:0] hour_pre;
  logic       hour_clear;
  logic [5:0] hour_plus;
  logic [2:0] cursor_inc;
  logic [2:0] cursor_new;
  logic [7:0] entered;
  logic [7:0] hour_limit;

  // Seconds, minutes and hours ripple for a second tick
  always_comb begin
    count_inc  = {1'b0, cur.prescale_count} + 9'd1;
    last_hour  = cur.format_24h ? tdc_pkg::LAST_HOUR_24 : tdc_pkg::LAST_HOUR_12;
    sec_wrap   = (cur.second >= tdc_pkg::LAST_MINUTE);
    tick_sec   = sec_wrap ? 6'd0 : cur.second + 6'd1;
    min_pre    = {1'b0, cur.minute} + {6'd0, sec_wrap};
    min_wrap   = (min_pre > {1'b0, tdc_pkg::LAST_MINUTE});
    tick_min   = min_wrap ? 6'd0 : min_pre[5:0];
    hour_pre   = {1'b0, cur.hour} + {5'd0, min_wrap};
    hour_clear = (hour_pre > {1'b0, last_hour});
    hour_plus  = {1'b0, cur.hour} + {1'b0, tdc_pkg::HALF_DAY};
    cursor_inc = cur.cursor + 3'd1;
    cursor_new = (cursor_inc == tdc_pkg::CUR_COMMIT) ? tdc_pkg::CUR_OFF : cursor_inc;
    entered    = {4'd0, cur.tens_digit} * 8'd10 + {4'd0, key_digit};
    hour_limit = {3'd0, last_hour};
  end

  // Apply the command
  always_comb begin
    nxt   = cur;
    pulse = 1'b0;
    case (tdc_pkg::cmd_t'(cmd))
      tdc_pkg::CMD_TICK: begin
        if (count_inc > {1'b0, cfg.tick_divide}) begin
          nxt.prescale_count = 8'd0;
          pulse              = 1'b1;
          if (hour_clear) begin
            nxt.hour   = 5'd0;
            nxt.minute = 6'd0;
            nxt.second = 6'd0;
          end else begin
            nxt.hour   = hour_pre[4:0];
            nxt.minute = tick_min;
            nxt.second = tick_sec;
          end
        end else begin
          nxt.prescale_count = count_inc[7:0];
        end
      end
      tdc_pkg::CMD_FORMAT: begin
        if (adc_value >= cfg.format_threshold) begin
          if (cur.pm) begin
            nxt.hour = (hour_plus > {1'b0, tdc_pkg::LAST_HOUR_24}) ?
                       tdc_pkg::LAST_HOUR_24 : hour_plus[4:0];
            nxt.pm   = 1'b0;
          end
          nxt.format_24h = 1'b1;
        end else begin
          if (cur.hour > tdc_pkg::HALF_DAY) begin
            nxt.hour = cur.hour - tdc_pkg::HALF_DAY;
            nxt.pm   = 1'b1;
          end
          nxt.format_24h = 1'b0;
        end
      end
      tdc_pkg::CMD_SET: begin
        nxt.cursor = cursor_new;
        // Seventh press: commit the staged time
        if (cursor_inc == tdc_pkg::CUR_COMMIT) begin
          nxt.hour   = cur.staged_hour;
          nxt.minute = cur.staged_minute;
          nxt.second = cur.staged_second;
        end
        case (cursor_new)
          tdc_pkg::CUR_HOUR_TENS,
          tdc_pkg::CUR_MIN_TENS,
          tdc_pkg::CUR_SEC_TENS:   nxt.tens_digit = key_digit;
          tdc_pkg::CUR_HOUR_UNITS: nxt.staged_hour =
              (entered > hour_limit) ? last_hour : entered[4:0];
          tdc_pkg::CUR_MIN_UNITS:  nxt.staged_minute =
              (entered > {2'd0, tdc_pkg::LAST_MINUTE}) ? tdc_pkg::LAST_MINUTE : entered[5:0];
          tdc_pkg::CUR_SEC_UNITS:  nxt.staged_second =
              (entered > {2'd0, tdc_pkg::LAST_MINUTE}) ? tdc_pkg::LAST_MINUTE : entered[5:0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/time_of_day_clock_with_set_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_day_clock_with_set_core: hours/minutes/seconds clock with keypad set
// Usage:
//   item   - command words: timer overflow, format sample (ADC reading),
//            set-button press with a keypad digit, or idle.
//   result - one word per command: the time, the 12/24-hour mode, the set
//            cursor and a flag marking a command that advanced the seconds.
//   cfg_*  - write port for tick_divide (index 0) and format_threshold
//            (index 1); write only while no command is in flight.
// A command is registered in the input register on acceptance, and its result
// is registered in the result register once that register is free.
// One command per cycle is taken while the receiver does not stall; the clock
// state register closes the only loop. Reset sets the time to 22:00:00 in
// 24-hour mode, clears the prescaler and cursor and restores the register
// defaults. When the receiver stalls, the result register holds its word and
// the input register fills, after which item.ready drops until the result is
// taken.
// ----------------------------------------------------------------------------
module time_of_day_clock_with_set_core (
  input  logic                            clk,
  input  logic                            rst,
  tdc_item_if.sink                        item,
  tdc_result_if.source                    result,
  input  logic                            cfg_write,
  input  logic [tdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tdc_pkg::cfg_t   cfg;
  tdc_pkg::state_t st;
  tdc_pkg::state_t st_next;
  logic            pulse_next;

  logic            in_valid;
  logic [1:0]      in_cmd;
  logic [9:0]      in_adc_value;
  logic [3:0]      in_key_digit;

  logic            out_valid;
  logic [4:0]      out_hours;
  logic [5:0]      out_minutes;
  logic [5:0]      out_seconds;
  logic            out_mode_24h;
  logic [2:0]      out_set_cursor;
  logic            out_second_pulse;

  logic            out_free;
  logic            advance;

  tdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tdc_step u_step (
    .cfg       (cfg),
    .cur       (st),
    .cmd       (in_cmd),
    .adc_value (in_adc_value),
    .key_digit (in_key_digit),
    .nxt       (st_next),
    .pulse     (pulse_next)
  );

  // Handshake: move the input word on when the result register is free
  assign out_free   = !out_valid || result.ready;
  assign advance    = in_valid && out_free;
  assign item.ready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_cmd       <= item.cmd;
      in_adc_value <= item.adc_value;
      in_key_digit <= item.key_digit;
    end
  end

  // Clock state: advance with each word that passes to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= tdc_pkg::STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hours        <= st_next.hour;
      out_minutes      <= st_next.minute;
      out_seconds      <= st_next.second;
      out_mode_24h     <= st_next.format_24h;
      out_set_cursor   <= st_next.cursor;
      out_second_pulse <= pulse_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.hours        = out_hours;
  assign result.minutes      = out_minutes;
  assign result.seconds      = out_seconds;
  assign result.mode_24h     = out_mode_24h;
  assign result.set_cursor   = out_set_cursor;
  assign result.second_pulse = out_second_pulse;

  // Checks
  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("word advanced but no result word followed");

  a_pulse_clears_prescaler: assert property (@(posedge clk) disable iff (rst)
    $past(advance) && out_second_pulse |-> st.prescale_count == 8'd0)
    else $error("second advanced without clearing the prescaler");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    st.cursor != tdc_pkg::CUR_COMMIT)
    else $error("set cursor left on the commit position");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    st.hour <= tdc_pkg::LAST_HOUR_24 && st.minute <= tdc_pkg::LAST_MINUTE &&
    st.second <= tdc_pkg::LAST_MINUTE)
    else $error("time out of range");

  a_empty_input_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> item.ready)
    else $error("input register empty but not ready");

endmodule

// ===== sim/time_of_day_clock_with_set_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_day_clock_with_set_core_tb: self-checking bench for the clock core
// Sends command words through the item channel. A bench-side copy of the
// clock state predicts every result word, and each word the core returns is
// checked field by field against the oldest prediction. The run starts with
// hand-picked sequences: format switches, hour rollover in both modes, digit
// clamps and a commit across a mode change. Random phases follow, each with
// its own divider and threshold and its own pattern of sender gaps and
// receiver stalls. The run ends with a stretch of ticks at the largest divider.
// ----------------------------------------------------------------------------
module time_of_day_clock_with_set_core_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_WORDS = 110;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       mode_24h;
    logic [2:0] set_cursor;
    logic       second_pulse;
  } clock_word_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_write;
  logic [tdc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [tdc_pkg::CFG_DATA_W-1:0]  cfg_data;

  tdc_item_if   item_ch ();
  tdc_result_if result_ch ();

  time_of_day_clock_with_set_core dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bench copy of the clock and its registers
  tdc_pkg::state_t tod_state;
  tdc_pkg::cfg_t   tod_cfg;
  clock_word_t     pending_times[$];

  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  int fail_count      = 0;
  int quiet_cycles    = 0;
  int words_sent      = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Keypad entry: tens*10+units, clamped to the limit
  function automatic logic [5:0] clamp_entry(logic [3:0] tens, logic [3:0] units,
                                             int limit);
    int v;
    v = int'(tens) * 10 + int'(units);
    return 6'((v > limit) ? limit : v);
  endfunction

  // Apply one command word to the bench clock and return the result word
  function automatic clock_word_t advance_clock(tdc_pkg::cmd_t cmd, logic [9:0] adc,
                                                logic [3:0] digit);
    clock_word_t w;
    int          hr, mn, sc, nxt, top;
    logic [2:0]  pos;
    logic        pulse;
    hr    = tod_state.hour;
    mn    = tod_state.minute;
    sc    = tod_state.second;
    pulse = 1'b0;
    top   = tod_state.format_24h ? int'(tdc_pkg::LAST_HOUR_24) :
                                   int'(tdc_pkg::LAST_HOUR_12);
    case (cmd)
      tdc_pkg::CMD_TICK: begin
        nxt = int'(tod_state.prescale_count) + 1;
        if (nxt > int'(tod_cfg.tick_divide)) begin
          tod_state.prescale_count = 8'd0;
          pulse = 1'b1;
          sc++;
          if (sc > int'(tdc_pkg::LAST_MINUTE)) begin
            sc = 0;
            mn++;
          end
          if (mn > int'(tdc_pkg::LAST_MINUTE)) begin
            mn = 0;
            hr++;
          end
          // past the last hour of the mode: clear the whole time
          if (hr > top) begin
            hr = 0;
            mn = 0;
            sc = 0;
          end
        end else begin
          tod_state.prescale_count = 8'(nxt);
        end
      end
      tdc_pkg::CMD_FORMAT: begin
        if (adc >= tod_cfg.format_threshold) begin
          if (tod_state.pm) begin
            hr += int'(tdc_pkg::HALF_DAY);
            if (hr > int'(tdc_pkg::LAST_HOUR_24)) hr = int'(tdc_pkg::LAST_HOUR_24);
            tod_state.pm = 1'b0;
          end
          tod_state.format_24h = 1'b1;
        end else begin
          if (hr > int'(tdc_pkg::HALF_DAY)) begin
            hr -= int'(tdc_pkg::HALF_DAY);
            tod_state.pm = 1'b1;
          end
          tod_state.format_24h = 1'b0;
        end
      end
      tdc_pkg::CMD_SET: begin
        pos = tod_state.cursor + 3'd1;
        if (pos == tdc_pkg::CUR_COMMIT) begin
          hr  = tod_state.staged_hour;
          mn  = tod_state.staged_minute;
          sc  = tod_state.staged_second;
          pos = tdc_pkg::CUR_OFF;
        end
        tod_state.cursor = pos;
        case (pos)
          tdc_pkg::CUR_HOUR_TENS, tdc_pkg::CUR_MIN_TENS, tdc_pkg::CUR_SEC_TENS:
            tod_state.tens_digit = digit;
          tdc_pkg::CUR_HOUR_UNITS:
            tod_state.staged_hour = 5'(clamp_entry(tod_state.tens_digit, digit, top));
          tdc_pkg::CUR_MIN_UNITS:
            tod_state.staged_minute = clamp_entry(tod_state.tens_digit, digit,
                                                  int'(tdc_pkg::LAST_MINUTE));
          tdc_pkg::CUR_SEC_UNITS:
            tod_state.staged_second = clamp_entry(tod_state.tens_digit, digit,
                                                  int'(tdc_pkg::LAST_MINUTE));
          default: ;
        endcase
      end
      default: ;
    endcase
    tod_state.hour   = 5'(hr);
    tod_state.minute = 6'(mn);
    tod_state.second = 6'(sc);
    w.hours        = tod_state.hour;
    w.minutes      = tod_state.minute;
    w.seconds      = tod_state.second;
    w.mode_24h     = tod_state.format_24h;
    w.set_cursor   = tod_state.cursor;
    w.second_pulse = pulse;
    return w;
  endfunction

  // Drive one command word, hold it until taken, then log its prediction
  task automatic send_word(tdc_pkg::cmd_t cmd, logic [9:0] adc, logic [3:0] digit);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.cmd       <= cmd;
    item_ch.adc_value <= adc;
    item_ch.key_digit <= digit;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    pending_times.push_back(advance_clock(cmd, adc, digit));
    if (cmd != tdc_pkg::CMD_IDLE) words_sent++;
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic settle_clock();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending_times.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [tdc_pkg::CFG_INDEX_W-1:0] idx,
                                logic [tdc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == tdc_pkg::REG_TICK_DIVIDE) tod_cfg.tick_divide = data[7:0];
    else tod_cfg.format_threshold = data;
  endtask

  task automatic configure(logic [7:0] divide, logic [9:0] threshold);
    settle_clock();
    write_register(tdc_pkg::REG_TICK_DIVIDE, tdc_pkg::CFG_DATA_W'(divide));
    write_register(tdc_pkg::REG_FORMAT_THRESHOLD, threshold);
  endtask

  // Six digit presses and the committing press
  task automatic enter_time(logic [3:0] ht, logic [3:0] hu, logic [3:0] mt,
                            logic [3:0] mu, logic [3:0] st, logic [3:0] su);
    logic [3:0] keys [7];
    keys = '{ht, hu, mt, mu, st, su, 4'($urandom_range(0, 15))};
    foreach (keys[i])
      send_word(tdc_pkg::CMD_SET, 10'($urandom_range(0, 1023)), keys[i]);
  endtask

  task automatic report_field(string label, int want, int seen);
    if (want != seen) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, seen);
      fail_count++;
    end
  endtask

  // Check each returned word against the oldest prediction
  always @(posedge clk) begin
    clock_word_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready) begin
      if (pending_times.size() == 0) begin
        $display("%0t ns: result word with none expected, expected nothing, actual %0d:%0d:%0d",
                 $time, result_ch.hours, result_ch.minutes, result_ch.seconds);
        fail_count++;
      end else begin
        want = pending_times.pop_front();
        report_field("hours", want.hours, result_ch.hours);
        report_field("minutes", want.minutes, result_ch.minutes);
        report_field("seconds", want.seconds, result_ch.seconds);
        report_field("mode_24h", want.mode_24h, result_ch.mode_24h);
        report_field("set_cursor", want.set_cursor, result_ch.set_cursor);
        report_field("second_pulse", want.second_pulse, result_ch.second_pulse);
      end
    end
  end

  // Stall the receiver at random
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("time_of_day_clock_with_set_core verification failed");
      $finish;
    end
  end

  // Hand-picked sequences with a divider of zero, so every tick is a second
  task automatic test_directed();
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    configure(8'd0, 10'd512);
    send_word(tdc_pkg::CMD_IDLE, 10'd1023, 4'd15);
    // stage 12:59:58 in 24-hour mode, then switch to 12-hour before commit
    send_word(tdc_pkg::CMD_SET, 10'd0, 4'd1);
    send_word(tdc_pkg::CMD_SET, 10'd0, 4'd2);
    send_word(tdc_pkg::CMD_SET, 10'd0, 4'd5);
    send_word(tdc_pkg::CMD_SET, 10'd0, 4'd9);
    send_word(tdc_pkg::CMD_SET, 10'd0, 4'd5);
    send_word(tdc_pkg::CMD_SET, 10'd0, 4'd8);
    send_word(tdc_pkg::CMD_FORMAT, 10'd0, 4'd0);
    send_word(tdc_pkg::CMD_SET, 10'd0, 4'd0);
    // hour of exactly twelve stays; back to 24-hour caps at 23
    send_word(tdc_pkg::CMD_FORMAT, 10'd0, 4'd0);
    send_word(tdc_pkg::CMD_FORMAT, 10'd1023, 4'd0);
    // roll over the full day
    send_word(tdc_pkg::CMD_TICK, 10'd0, 4'd0);
    send_word(tdc_pkg::CMD_TICK, 10'd0, 4'd0);
    // 12-hour entry with clamps, then rollover at the last 12-hour second
    send_word(tdc_pkg::CMD_FORMAT, 10'd511, 4'd0);
    enter_time(4'd9, 4'd9, 4'd15, 4'd15, 4'd5, 4'd9);
    send_word(tdc_pkg::CMD_TICK, 10'd0, 4'd0);
    send_word(tdc_pkg::CMD_FORMAT, 10'd512, 4'd0);
  endtask

  // Random mix, mostly complete set rounds and tick bursts
  task automatic test_random_mix(int idle_pct, int stall_pct, logic [7:0] divide,
                                 logic [9:0] threshold);
    int start, pick, burst, adc;
    configure(divide, threshold);
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    start = words_sent;
    while (words_sent - start < PHASE_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // finish any open round so the next one lines up
        while (tod_state.cursor != tdc_pkg::CUR_OFF)
          send_word(tdc_pkg::CMD_SET, 10'($urandom_range(0, 1023)),
                    4'($urandom_range(0, 15)));
        if ($urandom_range(0, 2) == 0) begin
          if (tod_state.format_24h)
            enter_time(4'd2, 4'd3, 4'd5, 4'd9, 4'd5, 4'($urandom_range(5, 9)));
          else
            enter_time(4'd1, 4'd1, 4'd5, 4'd9, 4'd5, 4'($urandom_range(5, 9)));
        end else if ($urandom_range(0, 7) == 0) begin
          enter_time(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        end else begin
          enter_time(4'($urandom_range(0, 2)), 4'($urandom_range(0, 9)),
                     4'($urandom_range(0, 5)), 4'($urandom_range(0, 9)),
                     4'($urandom_range(0, 5)), 4'($urandom_range(0, 9)));
        end
      end else if (pick < 40) begin
        // broken round: a few presses only
        repeat ($urandom_range(1, 6))
          send_word(tdc_pkg::CMD_SET, 10'($urandom_range(0, 1023)),
                    4'($urandom_range(0, 15)));
      end else if (pick < 75) begin
        burst = $urandom_range(1, 24);
        repeat (burst)
          send_word(tdc_pkg::CMD_TICK, 10'($urandom_range(0, 1023)),
                    4'($urandom_range(0, 15)));
      end else if (pick < 88) begin
        if ($urandom_range(0, 1) == 0) begin
          adc = $urandom_range(0, 1023);
        end else begin
          adc = int'(tod_cfg.format_threshold) + int'($urandom_range(0, 2)) - 1;
          if (adc < 0) adc = 0;
          if (adc > 1023) adc = 1023;
        end
        send_word(tdc_pkg::CMD_FORMAT, 10'(adc), 4'($urandom_range(0, 15)));
      end else begin
        send_word(tdc_pkg::cmd_t'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                  4'($urandom_range(0, 15)));
      end
    end
  endtask

  // Largest divider: a second every 256 ticks
  task automatic test_largest_divider();
    configure(8'd255, 10'($urandom_range(0, 1023)));
    sender_idle_pct = 24;
    sink_stall_pct  = 24;
    repeat (260)
      send_word(tdc_pkg::CMD_TICK, 10'($urandom_range(0, 1023)),
                4'($urandom_range(0, 15)));
  endtask

  initial begin
    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = tdc_pkg::REG_TICK_DIVIDE;
    cfg_data          = '0;
    item_ch.valid     = 1'b0;
    item_ch.cmd       = tdc_pkg::CMD_IDLE;
    item_ch.adc_value = '0;
    item_ch.key_digit = '0;
    tod_state         = tdc_pkg::STATE_RESET;
    tod_cfg           = '{tick_divide: tdc_pkg::TICK_DIVIDE_RESET,
                          format_threshold: tdc_pkg::FORMAT_THRESHOLD_RESET};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix(0, 0, 8'd1, 10'd0);
    test_random_mix(45, 0, tdc_pkg::TICK_DIVIDE_RESET, 10'd1023);
    test_random_mix(0, 45, 8'($urandom_range(2, 9)), 10'($urandom_range(0, 1023)));
    test_random_mix(24, 24, 8'd0, tdc_pkg::FORMAT_THRESHOLD_RESET);
    test_largest_divider();
    settle_clock();

    if (fail_count == 0) begin
      $display("time_of_day_clock_with_set_core verification clean");
    end else begin
      $display("time_of_day_clock_with_set_core verification failed");
    end
    $finish;
  end

endmodule
